// ===== design/fte_pkg.sv =====
// Shared constants, types and a helper function for the Fenwick tree engine.
package fte_pkg;

  // Number of index positions the store can hold.
  localparam int CAPACITY = 1024;

  // Store address width and widths of position values.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int N_W    = $clog2(CAPACITY + 1);
  localparam int POS_W  = N_W + 1;

  // Fixed field widths of the request, response and size register.
  localparam int CMD_W   = 2;
  localparam int INDEX_W = 11;
  localparam int DELTA_W = 32;
  localparam int VALUE_W = 48;
  localparam int CFG_W   = 11;

  // Size register value after reset.
  localparam logic [CFG_W-1:0] TREE_SIZE_RST = 11'd1024;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    OP_ADD   = 2'd0,
    OP_SUM   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_start;
    logic walk_first;
    logic walk_second;
    logic clr_start;
    logic out_load;
  } fte_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_busy;
    logic walk_busy;
    logic add_bad;
  } fte_stat_t;

  // Maps a written size to the size in use: zero becomes one, and values
  // above the capacity become the capacity.
  function automatic logic [N_W-1:0] size_in_use(input logic [CFG_W-1:0] v);
    logic [N_W-1:0] s;
    if (v == '0) begin
      s = N_W'(1);
    end else if (32'(v) > 32'(CAPACITY)) begin
      s = N_W'(CAPACITY);
    end else begin
      s = N_W'(v);
    end
    return s;
  endfunction

endpackage

// ===== design/fte_in_if.sv =====
// Request channel: command, index and delta with a valid/ready handshake.
interface fte_in_if;
  logic                          valid;
  logic                          ready;
  logic [fte_pkg::CMD_W-1:0]     cmd;
  logic [fte_pkg::INDEX_W-1:0]   index;
  logic signed [fte_pkg::DELTA_W-1:0] delta;

  modport source (output valid, output cmd, output index, output delta, input ready);
  modport sink   (input valid, input cmd, input index, input delta, output ready);
endinterface

// ===== design/fte_out_if.sv =====
// Response channel: value and status with a valid/ready handshake.
interface fte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fte_pkg::VALUE_W-1:0] value;
  logic                               status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== design/fte_ctrl.sv =====
// Controller state machine that sequences tree walks, clears and responses.
module fte_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [fte_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  fte_pkg::fte_stat_t        stat,
  output fte_pkg::fte_ctl_t         ctl
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK1 = 5'b00010,
    S_WALK2 = 5'b00100,
    S_CLEAR = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   qry, qry_next;
  logic   out_valid_next;
  logic   accept;

  // A new request is taken only when idle and no clearing pass runs.
  assign in_ready = (state == S_IDLE) && !stat.clr_busy;
  assign accept   = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    qry_next   = qry;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.item_start = 1'b1;
          qry_next       = (in_cmd == fte_pkg::OP_QUERY);
          case (in_cmd)
            fte_pkg::OP_ADD: begin
              if (stat.add_bad) begin
                state_next = S_DONE;
              end else begin
                ctl.walk_first = 1'b1;
                state_next     = S_WALK1;
              end
            end
            fte_pkg::OP_SUM, fte_pkg::OP_QUERY: begin
              ctl.walk_first = 1'b1;
              state_next     = S_WALK1;
            end
            fte_pkg::OP_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_WALK1: begin
        if (!stat.walk_busy) begin
          if (qry) begin
            ctl.walk_second = 1'b1;
            state_next      = S_WALK2;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_WALK2: begin
        if (!stat.walk_busy) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        if (!stat.clr_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Response valid is set on a load and cleared by a transfer.
  always_comb begin
    if (ctl.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qry       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      qry       <= qry_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== design/fte_dp.sv =====
// Datapath: partial sum store, walk position, accumulator, clearing sweep and responses.
module fte_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  fte_pkg::fte_ctl_t                  ctl,
  output fte_pkg::fte_stat_t                 stat,
  input  logic                               cfg_wr_en,
  input  logic [fte_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic [fte_pkg::CMD_W-1:0]          in_cmd,
  input  logic [fte_pkg::INDEX_W-1:0]        in_index,
  input  logic signed [fte_pkg::DELTA_W-1:0] in_delta,
  output logic signed [fte_pkg::VALUE_W-1:0] out_value,
  output logic                               out_status
);

  localparam int ADDR_W  = fte_pkg::ADDR_W;
  localparam int N_W     = fte_pkg::N_W;
  localparam int POS_W   = fte_pkg::POS_W;
  localparam int VALUE_W = fte_pkg::VALUE_W;
  localparam int DELTA_W = fte_pkg::DELTA_W;

  logic [VALUE_W-1:0] mem [fte_pkg::CAPACITY];

  logic [N_W-1:0]     n;
  logic [N_W-1:0]     idx_clamp;
  logic               idx_over;
  logic [N_W-1:0]     base;
  logic [VALUE_W-1:0] delta48;
  logic               add_mode;
  logic               sub;
  logic               err;
  logic [VALUE_W-1:0] acc;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   pos_m1;
  logic [POS_W-1:0]   low;
  logic               walk_on;
  logic               issue;
  logic [ADDR_W-1:0]  addr;
  logic               rd_valid;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               clr_busy;
  logic [ADDR_W-1:0]  clr_cnt;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [VALUE_W-1:0] mem_wd;

  // Size in use, loaded from the size register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= fte_pkg::size_in_use(fte_pkg::TREE_SIZE_RST);
    end else if (cfg_wr_en) begin
      n <= fte_pkg::size_in_use(cfg_wr_data);
    end
  end

  // Index range check and clamp against the size in use.
  assign idx_over  = 32'(in_index) > 32'(n);
  assign idx_clamp = idx_over ? n : N_W'(in_index);

  // Walk step: the current position, its lowest set bit and its address.
  assign issue  = walk_on && (pos != '0) && (pos <= POS_W'(n));
  assign low    = pos & (~pos + POS_W'(1));
  assign pos_m1 = pos - POS_W'(1);
  assign addr   = pos_m1[ADDR_W-1:0];

  // Item setup registers.
  always_ff @(posedge clk) begin
    if (ctl.item_start) begin
      base     <= idx_clamp;
      delta48  <= {{(VALUE_W - DELTA_W){in_delta[DELTA_W-1]}}, in_delta};
      add_mode <= (in_cmd == fte_pkg::OP_ADD);
      err      <= (in_cmd == fte_pkg::OP_ADD) && ((in_index == '0) || idx_over);
    end
  end

  // Walk position: upward by the lowest set bit for an add, downward for a sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_on  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (ctl.walk_first) begin
        walk_on <= 1'b1;
        pos     <= {1'b0, idx_clamp};
        sub     <= 1'b0;
      end else if (ctl.walk_second) begin
        walk_on <= 1'b1;
        pos     <= (base == '0) ? '0 : {1'b0, base - N_W'(1)};
        sub     <= 1'b1;
      end else if (issue) begin
        pos <= add_mode ? (pos + low) : (pos - low);
      end else begin
        walk_on <= 1'b0;
      end
    end
  end

  // Address of the entry whose read data arrives next cycle.
  always_ff @(posedge clk) begin
    rd_addr <= addr;
  end

  // Accumulator for prefix sums; the second query walk subtracts.
  always_ff @(posedge clk) begin
    if (ctl.item_start) begin
      acc <= '0;
    end else if (rd_valid && !add_mode) begin
      acc <= sub ? (acc - rd_data) : (acc + rd_data);
    end
  end

  // Clearing sweep, one entry per cycle, after reset, a size write or a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (cfg_wr_en || ctl.clr_start) begin
      clr_busy <= 1'b1;
      clr_cnt  <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
      if (clr_cnt == ADDR_W'(fte_pkg::CAPACITY - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // Store write port: clearing sweep or add write-back.
  assign mem_we = clr_busy || (rd_valid && add_mode);
  assign mem_wa = clr_busy ? clr_cnt : rd_addr;
  assign mem_wd = clr_busy ? '0 : (rd_data + delta48);

  // Partial sum store with a registered read port.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[addr];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Response registers.
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_value  <= acc;
      out_status <= err;
    end
  end

  // Status to the controller.
  assign stat.clr_busy  = clr_busy;
  assign stat.walk_busy = issue || rd_valid;
  assign stat.add_bad   = (in_index == '0) || idx_over;

endmodule

// ===== design/fenwick_tree_engine_top.sv =====
// Fenwick tree engine: a binary indexed tree of 1024 signed 48-bit partial
// sums with point add, prefix sum, point query and clear commands. One
// request is handled at a time and each gives one response; the response
// register lets the next request be taken while a response waits. The
// store has one read and one write port and the tree walk reads one entry
// per cycle, pipelined. An add reads at most 11 entries and a prefix sum
// at most 10; a point query runs two walks. A clear command, reset and
// every write of the size register start a clearing pass over all 1024
// entries of the store. During the pass req.ready stays low, and a clear
// command responds when its pass ends. Sums wrap at 48 bits; an add at
// index 0 or above the size in use changes nothing and responds with
// status 1.
module fenwick_tree_engine_top (
  input  logic                      clk,
  input  logic                      rst,
  fte_in_if.sink                    req,
  fte_out_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic [fte_pkg::CFG_W-1:0] cfg_wr_data
);

  fte_pkg::fte_ctl_t  ctl;
  fte_pkg::fte_stat_t stat;

  // Sequencing of walks, clears and responses.
  fte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_cmd    (req.cmd),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Store, walk and accumulation.
  fte_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_cmd      (req.cmd),
    .in_index    (req.index),
    .in_delta    (req.delta),
    .out_value   (rsp.value),
    .out_status  (rsp.status)
  );

endmodule

// ===== design/fte_chk.sv =====
// Port-level checks for the Fenwick tree engine and their binding.
module fte_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [fte_pkg::VALUE_W-1:0] rsp_value,
  input logic                        rsp_status,
  input logic                        cfg_wr_en
);

  // A stalled response holds its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
    else $error("response changed while stalled");

  // Requests are handled one at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  // A size write starts a clearing pass that blocks requests.
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> !req_ready)
    else $error("request ready right after a size write");

  // The store is being cleared right after reset.
  a_rst_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !req_ready)
    else $error("request ready right after reset");

  // A rejected add always answers zero.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_value == '0)
    else $error("error response with nonzero value");

endmodule

bind fenwick_tree_engine_top fte_chk u_fte_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.value),
  .rsp_status (rsp.status),
  .cfg_wr_en  (cfg_wr_en)
);
